// ===== rtl/dhoat_pkg.sv =====
// Shared constants, codes and types for the double-hashing open-address table.
// Used by dhoat_mod_unit and double_hash_open_address_table_unit.
`timescale 1ns / 1ps
`default_nettype none

package dhoat_pkg;

   localparam int MAX_SLOTS = 1024;
   localparam int IDX_W     = $clog2(MAX_SLOTS);
   localparam int KEY_W     = 31;
   localparam int CFG_W     = 11;
   localparam int SLOT_W    = 10;
   localparam int COLL_W    = 11;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int MOD_CNT_W = $clog2(KEY_W + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_MOD = 1'b1;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(1024);
   localparam logic [CFG_W-1:0] SECOND_MOD_RST = CFG_W'(7);

   typedef enum logic [STAT_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // request to the shared remainder unit
   typedef struct packed {
      logic                 start;
      logic [KEY_W-1:0]     dividend;
      logic [CFG_W-1:0]     divisor;
      logic [MOD_CNT_W-1:0] steps;
   } mod_cmd_type;

   typedef struct packed {
      logic             done;
      logic [CFG_W-1:0] rem;
   } mod_res_type;

endpackage

`default_nettype wire

// ===== rtl/dhoat_mod_unit.sv =====
// Iterative restoring remainder unit: one dividend bit per cycle.
// Depends on dhoat_pkg for widths and the command/result structs.
`timescale 1ns / 1ps
`default_nettype none

module dhoat_mod_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dhoat_pkg::mod_cmd_type cmd,
   output      dhoat_pkg::mod_res_type res
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [dhoat_pkg::KEY_W-1:0]     dvd_ff, dvd_in;
   logic [dhoat_pkg::CFG_W-1:0]     rem_ff, rem_in;
   logic [dhoat_pkg::CFG_W-1:0]     div_ff, div_in;
   logic [dhoat_pkg::MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [dhoat_pkg::CFG_W:0]       trial;
   logic                            fits;

   always_comb begin
      trial   = {rem_ff, dvd_ff[dhoat_pkg::KEY_W-1]};
      fits    = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         dvd_in  = cmd.dividend;
         rem_in  = '0;
         div_in  = cmd.divisor;
         cnt_in  = cmd.steps;
      end else if (busy_ff) begin
         rem_in = fits ? dhoat_pkg::CFG_W'(trial - {1'b0, div_ff})
                       : trial[dhoat_pkg::CFG_W-1:0];
         dvd_in = {dvd_ff[dhoat_pkg::KEY_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == dhoat_pkg::MOD_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign res.done = done_ff;
   assign res.rem  = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/double_hash_open_address_table_unit.sv =====
// Open-addressed hash table of nonzero keys with double hashing; holds the slot store.
// Depends on dhoat_pkg and dhoat_mod_unit.
`timescale 1ns / 1ps
`default_nettype none

// One operation at a time. After reset the store is cleared one slot a cycle, and
// req_stall stays high until all 1024 slots are cleared. An operation then hashes
// key mod M, key mod q and step mod M, all on one bit-serial remainder unit, then
// probes the store, each probe a read and a compare, then loads the result register
// and hands it on when the output is free. Worst case is M probes. Config writes
// are taken at any time and must only be issued while the block is idle.
module double_hash_open_address_table_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic                              req_func,
   input  wire logic [dhoat_pkg::KEY_W-1:0]       req_key,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic [dhoat_pkg::STAT_W-1:0]      rsp_status,
   output      logic [dhoat_pkg::SLOT_W-1:0]      rsp_slot,
   output      logic [dhoat_pkg::COLL_W-1:0]      rsp_collisions,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [dhoat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dhoat_pkg::CFG_W-1:0]       csr_wdata
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_MOD_HOME, S_MOD_Q, S_MOD_STEP, S_READ, S_CHECK, S_DELIVER
   } state_type;

   localparam int PAD_W = dhoat_pkg::KEY_W - dhoat_pkg::CFG_W;

   state_type                        state_ff, state_in;
   logic [dhoat_pkg::IDX_W-1:0]      clr_idx_ff, clr_idx_in;
   logic                             func_ff, func_in;
   logic [dhoat_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [dhoat_pkg::CFG_W-1:0]      m_ff, m_in;
   logic [dhoat_pkg::CFG_W-1:0]      q_ff, q_in;
   logic [dhoat_pkg::IDX_W-1:0]      home_ff, home_in;
   logic [dhoat_pkg::IDX_W-1:0]      stepm_ff, stepm_in;
   logic [dhoat_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [dhoat_pkg::COLL_W-1:0]     coll_ff, coll_in;
   dhoat_pkg::status_type            res_status_ff, res_status_in;
   logic [dhoat_pkg::IDX_W-1:0]      res_slot_ff, res_slot_in;
   logic [dhoat_pkg::COLL_W-1:0]     res_coll_ff, res_coll_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   dhoat_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [dhoat_pkg::SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [dhoat_pkg::COLL_W-1:0]     rsp_coll_ff, rsp_coll_in;
   logic [dhoat_pkg::CFG_W-1:0]      csr_size_ff, csr_size_in;
   logic [dhoat_pkg::CFG_W-1:0]      csr_qmod_ff, csr_qmod_in;

   logic [dhoat_pkg::KEY_W-1:0]      slot_mem [dhoat_pkg::MAX_SLOTS];
   logic [dhoat_pkg::KEY_W-1:0]      rd_data_ff;
   logic                             wr_en;
   logic [dhoat_pkg::IDX_W-1:0]      wr_addr;
   logic [dhoat_pkg::KEY_W-1:0]      wr_data;

   dhoat_pkg::mod_cmd_type           mod_cmd;
   dhoat_pkg::mod_res_type           mod_res;

   logic                             req_beat;
   logic                             rsp_free;
   logic [dhoat_pkg::CFG_W-1:0]      eff_m;
   logic [dhoat_pkg::CFG_W-1:0]      eff_q;
   logic [dhoat_pkg::CFG_W-1:0]      step;
   logic [dhoat_pkg::CFG_W-1:0]      coll_next;
   logic [dhoat_pkg::IDX_W:0]        idx_sum;
   logic [dhoat_pkg::IDX_W:0]        idx_wrap;

   dhoat_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (mod_cmd),
      .res   (mod_res)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      priority if (csr_size_ff == '0) begin
         eff_m = dhoat_pkg::CFG_W'(1);
      end else if (csr_size_ff > dhoat_pkg::CFG_W'(dhoat_pkg::MAX_SLOTS)) begin
         eff_m = dhoat_pkg::CFG_W'(dhoat_pkg::MAX_SLOTS);
      end else begin
         eff_m = csr_size_ff;
      end
      eff_q     = (csr_qmod_ff == '0) ? dhoat_pkg::CFG_W'(1) : csr_qmod_ff;
      step      = q_ff - mod_res.rem;
      coll_next = coll_ff + 1'b1;
      idx_sum   = {1'b0, idx_ff} + {1'b0, stepm_ff};
      idx_wrap  = ({1'b0, idx_sum} >= {1'b0, m_ff})
                  ? (dhoat_pkg::IDX_W+1)'({1'b0, idx_sum} - {1'b0, m_ff}) : idx_sum;
   end

   always_comb begin
      mod_cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            mod_cmd.start    = req_beat;
            mod_cmd.dividend = req_key;
            mod_cmd.divisor  = eff_m;
            mod_cmd.steps    = dhoat_pkg::MOD_CNT_W'(dhoat_pkg::KEY_W);
         end
         S_MOD_HOME: begin
            mod_cmd.start    = mod_res.done;
            mod_cmd.dividend = key_ff;
            mod_cmd.divisor  = q_ff;
            mod_cmd.steps    = dhoat_pkg::MOD_CNT_W'(dhoat_pkg::KEY_W);
         end
         S_MOD_Q: begin
            mod_cmd.start    = mod_res.done;
            mod_cmd.dividend = {step, PAD_W'(0)};
            mod_cmd.divisor  = m_ff;
            mod_cmd.steps    = dhoat_pkg::MOD_CNT_W'(dhoat_pkg::CFG_W);
         end
         default: begin
            mod_cmd = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      m_in          = m_ff;
      q_in          = q_ff;
      home_in       = home_ff;
      stepm_in      = stepm_ff;
      idx_in        = idx_ff;
      coll_in       = coll_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_coll_in   = res_coll_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_coll_in   = rsp_coll_ff;
      csr_size_in   = csr_size_ff;
      csr_qmod_in   = csr_qmod_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = key_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dhoat_pkg::CSR_TABLE_SIZE: csr_size_in = csr_wdata;
            dhoat_pkg::CSR_SECOND_MOD: csr_qmod_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == dhoat_pkg::IDX_W'(dhoat_pkg::MAX_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_beat) begin
               func_in  = req_func;
               key_in   = req_key;
               m_in     = eff_m;
               q_in     = eff_q;
               state_in = S_MOD_HOME;
            end
         end
         S_MOD_HOME: begin
            if (mod_res.done) begin
               home_in  = dhoat_pkg::IDX_W'(mod_res.rem);
               state_in = S_MOD_Q;
            end
         end
         S_MOD_Q: begin
            if (mod_res.done) begin
               state_in = S_MOD_STEP;
            end
         end
         S_MOD_STEP: begin
            if (mod_res.done) begin
               stepm_in = dhoat_pkg::IDX_W'(mod_res.rem);
               idx_in   = home_ff;
               coll_in  = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in    = S_DELIVER;
            res_slot_in = '0;
            res_coll_in = coll_ff;
            priority if (rd_data_ff == '0) begin
               if (func_ff == dhoat_pkg::FUNC_INSERT) begin
                  wr_en         = 1'b1;
                  res_status_in = dhoat_pkg::ST_INSERTED;
                  res_slot_in   = idx_ff;
               end else begin
                  res_status_in = dhoat_pkg::ST_NOT_FOUND;
               end
            end else if (func_ff == dhoat_pkg::FUNC_SEARCH && rd_data_ff == key_ff) begin
               res_status_in = dhoat_pkg::ST_FOUND;
               res_slot_in   = idx_ff;
            end else if (coll_next == m_ff) begin
               res_status_in = (func_ff == dhoat_pkg::FUNC_INSERT)
                               ? dhoat_pkg::ST_FULL : dhoat_pkg::ST_NOT_FOUND;
               res_coll_in   = m_ff;
            end else begin
               coll_in  = coll_next;
               idx_in   = dhoat_pkg::IDX_W'(idx_wrap);
               state_in = S_READ;
            end
         end
         S_DELIVER: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = dhoat_pkg::SLOT_W'(res_slot_ff);
               rsp_coll_in   = res_coll_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         csr_size_ff  <= dhoat_pkg::TABLE_SIZE_RST;
         csr_qmod_ff  <= dhoat_pkg::SECOND_MOD_RST;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         csr_size_ff  <= csr_size_in;
         csr_qmod_ff  <= csr_qmod_in;
      end
      func_ff       <= func_in;
      key_ff        <= key_in;
      m_ff          <= m_in;
      q_ff          <= q_in;
      home_ff       <= home_in;
      stepm_ff      <= stepm_in;
      idx_ff        <= idx_in;
      coll_ff       <= coll_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_coll_ff   <= res_coll_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_coll_ff   <= rsp_coll_in;
   end

   // slot store: one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[idx_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_collisions = rsp_coll_ff;

   a_wr_state : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_CHECK))
      else $error("store write outside clear or probe check");

   a_probe_idx : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ({1'b0, idx_ff} < m_ff))
      else $error("probe index beyond table size");

   a_coll_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (coll_ff < m_ff))
      else $error("collision count reached table size while probing");

   a_mod_done : assert property (@(posedge clock) disable iff (reset)
      mod_res.done |-> (state_ff == S_MOD_HOME || state_ff == S_MOD_Q
                        || state_ff == S_MOD_STEP))
      else $error("remainder unit finished outside hashing");

endmodule

`default_nettype wire
